### rtl/tcca_pkg.sv
package tcca_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W       = 4;
    localparam int LIM_W       = 4;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 4;

    localparam logic [LIM_W-1:0] TOTAL_LIMIT_RST   = 4'd5;
    localparam logic [LIM_W-1:0] CLASS_A_LIMIT_RST = 4'd3;
    localparam logic [LIM_W-1:0] CLASS_B_LIMIT_RST = 4'd3;

    localparam logic [1:0] REG_TOTAL_LIMIT   = 2'd0;
    localparam logic [1:0] REG_CLASS_A_LIMIT = 2'd1;
    localparam logic [1:0] REG_CLASS_B_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        REQ_ENQ_A = 2'd0,
        REQ_ENQ_B = 2'd1,
        REQ_DEP_A = 2'd2,
        REQ_DEP_B = 2'd3
    } t_req_type;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_req_type          req_type;
        logic [ID_BITS-1:0] request_id;
    } t_in_item;

    typedef struct packed {
        logic               admit_valid;
        logic [ID_BITS-1:0] admit_id;
        logic               admit_class_b;
        logic               enqueue_dropped;
        logic [CNT_W-1:0]   holding_total;
        logic [CNT_W-1:0]   holding_class_a;
        logic [CNT_W-1:0]   holding_class_b;
        logic [FILL_W-1:0]  waiting_class_a;
        logic [FILL_W-1:0]  waiting_class_b;
    } t_out_item;

    typedef struct packed {
        logic [LIM_W-1:0] total_limit;
        logic [LIM_W-1:0] class_a_limit;
        logic [LIM_W-1:0] class_b_limit;
    } t_limits;

    typedef struct packed {
        logic               we;
        logic [PTR_W-1:0]   waddr;
        logic [ID_BITS-1:0] wdata;
        logic               re;
        logic [PTR_W-1:0]   raddr;
    } t_ram_req;

endpackage

### rtl/tcca_ram.sv
module tcca_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tcca_cfg.sv
module tcca_cfg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [tcca_pkg::APB_AW-1:0] paddr,
    input  logic [tcca_pkg::APB_DW-1:0] pwdata,
    output logic [tcca_pkg::APB_DW-1:0] prdata,
    output logic                    pready,
    output tcca_pkg::t_limits       o_limits
);
    import tcca_pkg::*;

    logic [LIM_W-1:0] r_total_limit;
    logic [LIM_W-1:0] r_class_a_limit;
    logic [LIM_W-1:0] r_class_b_limit;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_limit   <= TOTAL_LIMIT_RST;
            r_class_a_limit <= CLASS_A_LIMIT_RST;
            r_class_b_limit <= CLASS_B_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TOTAL_LIMIT:   r_total_limit   <= pwdata[LIM_W-1:0];
                REG_CLASS_A_LIMIT: r_class_a_limit <= pwdata[LIM_W-1:0];
                REG_CLASS_B_LIMIT: r_class_b_limit <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_TOTAL_LIMIT:   prdata[LIM_W-1:0] = r_total_limit;
            REG_CLASS_A_LIMIT: prdata[LIM_W-1:0] = r_class_a_limit;
            REG_CLASS_B_LIMIT: prdata[LIM_W-1:0] = r_class_b_limit;
            default:           prdata = '0;
        endcase
    end

    assign o_limits.total_limit   = r_total_limit;
    assign o_limits.class_a_limit = r_class_a_limit;
    assign o_limits.class_b_limit = r_class_b_limit;

endmodule

### rtl/tcca_core.sv
module tcca_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcca_pkg::t_limits    i_limits,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tcca_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tcca_pkg::t_out_item  o_out_item,
    output tcca_pkg::t_ram_req   o_ram_a,
    output tcca_pkg::t_ram_req   o_ram_b,
    input  logic [tcca_pkg::ID_BITS-1:0] i_rdata_a,
    input  logic [tcca_pkg::ID_BITS-1:0] i_rdata_b
);
    import tcca_pkg::*;

    localparam logic [PTR_W:0]    DEPTH_P = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    t_state r_state, n_state;

    logic [PTR_W-1:0]   r_head_a, n_head_a, r_head_b, n_head_b;
    logic [FILL_W-1:0]  r_fill_a, n_fill_a, r_fill_b, n_fill_b;
    logic [CNT_W-1:0]   r_cnt_t, n_cnt_t, r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic               r_adm, r_cls_b, r_fwd, r_drop;
    logic [ID_BITS-1:0] r_fwd_id;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item, n_out_item;

    logic               accept, out_free;
    logic               enq_a, enq_b, push_a, push_b, dep;
    logic               adm_a, adm_b, fwd, drop;
    logic [FILL_W-1:0]  fill_a1, fill_b1;
    logic [CNT_W-1:0]   cnt_t1, cnt_a1, cnt_b1;
    logic [PTR_W:0]     sum_a, sum_b;
    logic [PTR_W-1:0]   tail_a, tail_b;
    logic [ID_BITS-1:0] adm_id;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // event decode, queue tails and post-event counts
    always_comb begin
        enq_a  = (i_in_item.req_type == REQ_ENQ_A);
        enq_b  = (i_in_item.req_type == REQ_ENQ_B);
        dep    = !enq_a && !enq_b;
        push_a = enq_a && (r_fill_a != DEPTH_F);
        push_b = enq_b && (r_fill_b != DEPTH_F);
        drop   = (enq_a && !push_a) || (enq_b && !push_b);

        sum_a  = {1'b0, r_head_a} + r_fill_a[PTR_W:0];
        sum_b  = {1'b0, r_head_b} + r_fill_b[PTR_W:0];
        tail_a = (sum_a >= DEPTH_P) ? PTR_W'(sum_a - DEPTH_P) : sum_a[PTR_W-1:0];
        tail_b = (sum_b >= DEPTH_P) ? PTR_W'(sum_b - DEPTH_P) : sum_b[PTR_W-1:0];

        fill_a1 = r_fill_a + FILL_W'(push_a);
        fill_b1 = r_fill_b + FILL_W'(push_b);

        cnt_t1 = (dep && r_cnt_t != '0) ? r_cnt_t - 1'b1 : r_cnt_t;
        cnt_a1 = (i_in_item.req_type == REQ_DEP_A && r_cnt_a != '0) ?
                 r_cnt_a - 1'b1 : r_cnt_a;
        cnt_b1 = (i_in_item.req_type == REQ_DEP_B && r_cnt_b != '0) ?
                 r_cnt_b - 1'b1 : r_cnt_b;

        adm_a = (fill_a1 != '0) && (cnt_a1 < i_limits.class_a_limit) &&
                (cnt_t1 < i_limits.total_limit);
        adm_b = !adm_a && (fill_b1 != '0) && (cnt_b1 < i_limits.class_b_limit) &&
                (cnt_t1 < i_limits.total_limit);
        // an entry written by this same event is not yet visible at the read port
        fwd   = (adm_a && push_a && r_fill_a == '0) ||
                (adm_b && push_b && r_fill_b == '0);
    end

    always_comb begin
        o_ram_a.we    = accept && push_a;
        o_ram_a.waddr = tail_a;
        o_ram_a.wdata = i_in_item.request_id;
        o_ram_a.re    = accept;
        o_ram_a.raddr = r_head_a;
        o_ram_b.we    = accept && push_b;
        o_ram_b.waddr = tail_b;
        o_ram_b.wdata = i_in_item.request_id;
        o_ram_b.re    = accept;
        o_ram_b.raddr = r_head_b;
    end

    always_comb begin
        n_head_a = r_head_a;
        n_head_b = r_head_b;
        n_fill_a = r_fill_a;
        n_fill_b = r_fill_b;
        n_cnt_t  = r_cnt_t;
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        if (accept) begin
            n_fill_a = fill_a1 - FILL_W'(adm_a);
            n_fill_b = fill_b1 - FILL_W'(adm_b);
            n_cnt_t  = cnt_t1 + CNT_W'(adm_a || adm_b);
            n_cnt_a  = cnt_a1 + CNT_W'(adm_a);
            n_cnt_b  = cnt_b1 + CNT_W'(adm_b);
            if (adm_a) begin
                n_head_a = (r_head_a == LAST_P) ? '0 : r_head_a + 1'b1;
            end
            if (adm_b) begin
                n_head_b = (r_head_b == LAST_P) ? '0 : r_head_b + 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        adm_id      = r_fwd ? r_fwd_id : (r_cls_b ? i_rdata_b : i_rdata_a);
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                // hold the result until the output slot frees
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_item.admit_valid     = r_adm;
                    n_out_item.admit_id        = r_adm ? adm_id : '0;
                    n_out_item.admit_class_b   = r_adm && r_cls_b;
                    n_out_item.enqueue_dropped = r_drop;
                    n_out_item.holding_total   = r_cnt_t;
                    n_out_item.holding_class_a = r_cnt_a;
                    n_out_item.holding_class_b = r_cnt_b;
                    n_out_item.waiting_class_a = r_fill_a;
                    n_out_item.waiting_class_b = r_fill_b;
                    n_state                    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_head_a    <= '0;
            r_head_b    <= '0;
            r_fill_a    <= '0;
            r_fill_b    <= '0;
            r_cnt_t     <= '0;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_adm       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_head_a    <= n_head_a;
            r_head_b    <= n_head_b;
            r_fill_a    <= n_fill_a;
            r_fill_b    <= n_fill_b;
            r_cnt_t     <= n_cnt_t;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            if (accept) begin
                r_adm <= adm_a || adm_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        if (accept) begin
            r_cls_b  <= adm_b;
            r_fwd    <= fwd;
            r_fwd_id <= i_in_item.request_id;
            r_drop   <= drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/two_class_capacity_admission.sv
// Order: an accepted event beat moves the core to its read state; the result is
// registered from there once the output register is free, and can then be taken.
// The queue store's registered read port (issue head read, then use the data) lets
// the next event in only once the last result is registered; a result that is not
// taken holds off the next event until the output register frees.
// Reset: synchronous, active low; clears queue pointers, fill and holding counts,
// and loads the limits with 5, 3, 3. The queue stores are not cleared.
module two_class_capacity_admission (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tcca_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tcca_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcca_pkg::APB_AW-1:0] paddr,
    input  logic [tcca_pkg::APB_DW-1:0] pwdata,
    output logic [tcca_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import tcca_pkg::*;

    t_limits            limits;
    t_ram_req           ram_a, ram_b;
    logic [ID_BITS-1:0] rdata_a, rdata_b;

    tcca_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (limits)
    );

    tcca_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_BITS), .ADDR_W(PTR_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (ram_a.we),
        .i_waddr (ram_a.waddr),
        .i_wdata (ram_a.wdata),
        .i_re    (ram_a.re),
        .i_raddr (ram_a.raddr),
        .o_rdata (rdata_a)
    );

    tcca_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_BITS), .ADDR_W(PTR_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (ram_b.we),
        .i_waddr (ram_b.waddr),
        .i_wdata (ram_b.wdata),
        .i_re    (ram_b.re),
        .i_raddr (ram_b.raddr),
        .o_rdata (rdata_b)
    );

    tcca_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limits    (limits),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_ram_a     (ram_a),
        .o_ram_b     (ram_b),
        .i_rdata_a   (rdata_a),
        .i_rdata_b   (rdata_b)
    );

endmodule

### rtl/tcca_checker.sv
module tcca_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tcca_pkg::t_out_item o_out_item
);
    import tcca_pkg::*;

    // one event in flight: no new beat right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an event is in flight");

    a_no_admit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.admit_valid) |->
        (o_out_item.admit_id == '0 && !o_out_item.admit_class_b))
        else $error("admission fields set without an admission");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.waiting_class_a <= FILL_W'(QUEUE_DEPTH) &&
                         o_out_item.waiting_class_b <= FILL_W'(QUEUE_DEPTH)))
        else $error("queue fill beyond depth");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result beat dropped or changed while stalled");

endmodule

bind two_class_capacity_admission tcca_checker u_tcca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
